[rtl/core/rra_pkg.sv]
// Shared constants, codes and types of the round-robin id allocator.
package rra_pkg;

    localparam int MAX_IDS    = 1024;
    localparam int ID_W       = 11;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    localparam int WORD_IDX_W = ID_W - BIT_W;
    localparam int MAP_WORDS  = (MAX_IDS + 1 + WORD_BITS - 1) / WORD_BITS;
    localparam int VISIT_W    = WORD_IDX_W + 1;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic REG_MAX_IDS = 1'b0;

    typedef logic [ID_W-1:0]       id_t;
    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [WORD_IDX_W-1:0] word_idx_t;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_DISABLED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FIN
    } fsm_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_pos;
    } scan_t;

endpackage

[rtl/core/rra_if.sv]
// Request and response channel interfaces of the round-robin id allocator.
interface rra_req_if import rra_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        command;
    logic [ID_W-1:0] release_id;

    modport source (output valid, output command, output release_id, input ready);
    modport sink (input valid, input command, input release_id, output ready);
endinterface

interface rra_rsp_if import rra_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [ID_W-1:0] granted_id;
    logic [1:0]  status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink (input valid, input granted_id, input status, output ready);
endinterface

[rtl/core/rra_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[rtl/core/rra_scan.sv]
// Free-id search within one word of the used map.
module rra_scan import rra_pkg::*; (
    input  word_t            map_word,
    input  word_idx_t        word_idx,
    input  id_t              lim,
    input  logic [BIT_W-1:0] start_bit,
    input  logic             first,
    output scan_t            result
);

    word_idx_t lim_word;
    logic [BIT_W-1:0] lim_bit;
    word_t all_ones;
    word_t range_mask;
    word_t start_mask;
    word_t free_bits;

    assign lim_word = lim[ID_W-1:BIT_W];
    assign lim_bit  = lim[BIT_W-1:0];
    assign all_ones = '1;

    always_comb
    begin
        priority if (word_idx < lim_word)
        begin
            range_mask = all_ones;
        end
        else if (word_idx == lim_word)
        begin
            range_mask = all_ones >> (BIT_W'(WORD_BITS - 1) - lim_bit);
        end
        else
        begin
            range_mask = '0;
        end
        if (word_idx == '0)
        begin
            range_mask[0] = 1'b0;
        end
        start_mask = first ? (all_ones << start_bit) : all_ones;
        free_bits  = ~map_word & range_mask & start_mask;
    end

    always_comb
    begin
        result.found   = |free_bits;
        result.bit_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                result.bit_pos = BIT_W'(i);
            end
        end
    end

endmodule

[rtl/core/round_robin_id_allocator_core.sv]
// Top level of the round-robin id allocator: control, used-map memory and APB register.
//
//  Channel  | Role   | Payload                      | Transaction
//  ---------+--------+------------------------------+-----------------------------
//  req      | sink   | command, release_id          | valid && ready at clk rise
//  rsp      | source | granted_id, status           | valid && ready at clk rise
//  APB      | slave  | max_ids at byte address 0    | psel && penable && pwrite
//
// A release of an id from 1 to the limit passes through S_IDLE, S_EVAL and S_FIN;
// any other release and a refused allocate go from S_IDLE straight to S_FIN. An
// allocate scans the used map word by word in S_EVAL, through the single read port.
// Reset clears the used map at once through one valid flip-flop per memory word.
// A result stalled on the response side holds the next transaction in its final
// cycle, and nothing further is taken until the response is accepted.
module round_robin_id_allocator_core import rra_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    rra_req_if.sink            req,
    rra_rsp_if.source          rsp
);

    fsm_t state_reg, state_next;
    id_t max_ids_reg, max_ids_next;
    id_t count_reg, count_next;
    id_t cand_reg, cand_next;
    logic cmd_reg, cmd_next;
    id_t id_reg, id_next;
    word_idx_t word_reg, word_next;
    logic [BIT_W-1:0] start_bit_reg, start_bit_next;
    logic first_reg, first_next;
    logic [VISIT_W-1:0] visit_reg, visit_next;
    id_t res_id_reg, res_id_next;
    status_t res_status_reg, res_status_next;
    logic out_valid_reg, out_valid_next;
    id_t out_id_reg, out_id_next;
    status_t out_status_reg, out_status_next;
    logic [MAP_WORDS-1:0] word_valid_reg;
    logic rd_valid_reg;

    logic ram_we;
    logic ram_re;
    word_idx_t ram_waddr;
    word_idx_t ram_raddr;
    word_t ram_wdata;
    word_t ram_rdata;
    word_t map_data;
    id_t lim;
    word_idx_t lim_word;
    id_t start_id;
    id_t here;
    word_idx_t step_word;
    scan_t scan;
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MAX_IDS);
    assign prdata = (paddr[2] == REG_MAX_IDS) ?
                    {(PDATA_W - ID_W)'(0), max_ids_reg} : '0;

    assign lim      = (max_ids_reg > ID_W'(MAX_IDS)) ? ID_W'(MAX_IDS) : max_ids_reg;
    assign lim_word = lim[ID_W-1:BIT_W];
    assign map_data = rd_valid_reg ? ram_rdata : '0;
    assign here     = {word_reg, scan.bit_pos};
    assign start_id = ((cand_reg == '0) || (cand_reg > lim)) ? id_t'(1) : cand_reg;
    assign step_word = (word_reg >= lim_word) ? '0 : word_reg + word_idx_t'(1);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.granted_id = out_id_reg;
    assign rsp.status     = out_status_reg;

    rra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rra_scan u_scan (
        .map_word  (map_data),
        .word_idx  (word_reg),
        .lim       (lim),
        .start_bit (start_bit_reg),
        .first     (first_reg),
        .result    (scan)
    );

    always_comb
    begin
        state_next      = state_reg;
        max_ids_next    = cfg_we ? pwdata[ID_W-1:0] : max_ids_reg;
        count_next      = count_reg;
        cand_next       = cand_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        word_next       = word_reg;
        start_bit_next  = start_bit_reg;
        first_next      = first_reg;
        visit_next      = visit_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = word_reg;
        ram_wdata       = map_data;
        ram_re          = 1'b0;
        ram_raddr       = word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next        = req.command;
                    res_id_next     = '0;
                    res_status_next = ST_DONE;
                    if (req.command == CMD_RELEASE)
                    begin
                        if ((req.release_id != '0) && (req.release_id <= lim))
                        begin
                            id_next    = req.release_id;
                            word_next  = req.release_id[ID_W-1:BIT_W];
                            ram_re     = 1'b1;
                            ram_raddr  = req.release_id[ID_W-1:BIT_W];
                            state_next = S_EVAL;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        priority if (lim == '0)
                        begin
                            res_status_next = ST_DISABLED;
                            state_next      = S_FIN;
                        end
                        else if (count_reg >= lim)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            word_next      = start_id[ID_W-1:BIT_W];
                            start_bit_next = start_id[BIT_W-1:0];
                            first_next     = 1'b1;
                            visit_next     = '0;
                            ram_re         = 1'b1;
                            ram_raddr      = start_id[ID_W-1:BIT_W];
                            state_next     = S_EVAL;
                        end
                    end
                end
            end
            S_EVAL:
            begin
                if (cmd_reg == CMD_RELEASE)
                begin
                    if (map_data[id_reg[BIT_W-1:0]])
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = map_data & ~(word_t'(1) << id_reg[BIT_W-1:0]);
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - id_t'(1);
                        end
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    priority if (scan.found)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = map_data | (word_t'(1) << scan.bit_pos);
                        count_next      = count_reg + id_t'(1);
                        cand_next       = (here >= lim) ? id_t'(1) : here + id_t'(1);
                        res_id_next     = here;
                        res_status_next = ST_DONE;
                        state_next      = S_FIN;
                    end
                    else if (visit_reg == ({1'b0, lim_word} + VISIT_W'(1)))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        visit_next = visit_reg + VISIT_W'(1);
                        first_next = 1'b0;
                        word_next  = step_word;
                        ram_re     = 1'b1;
                        ram_raddr  = step_word;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = res_id_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_ids_reg    <= ID_W'(MAX_IDS);
            count_reg      <= '0;
            cand_reg       <= id_t'(1);
            out_valid_reg  <= 1'b0;
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_ids_reg   <= max_ids_next;
            count_reg     <= count_next;
            cand_reg      <= cand_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                word_valid_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re)
            begin
                rd_valid_reg <= word_valid_reg[ram_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        word_reg       <= word_next;
        start_bit_reg  <= start_bit_next;
        first_reg      <= first_next;
        visit_reg      <= visit_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ID_W'(MAX_IDS))
        else $error("In-use count exceeds the id range.");

    a_write_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EVAL))
        else $error("Used-map write outside the evaluation step.");

    a_refused_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_DONE)) |-> (rsp.granted_id == '0))
        else $error("Refused request carries a nonzero id.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("New transaction taken while one is in progress.");

endmodule

[bench/round_robin_id_allocator_core_tb.sv]
// Self-checking testbench for the round-robin id allocator core.
`timescale 1ns / 100ps

module round_robin_id_allocator_core_tb import rra_pkg::*; ();

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int IDLE_PCT        = 17;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int RELEASE_HELD_PCT = 80;
    localparam int DIRECTED_ROWS   = 29;
    localparam int RANDOM_PHASES   = 8;
    localparam int QUIET_PHASE     = 2;
    localparam int SQUEEZE_PHASE   = 5;

    typedef enum logic {
        ROW_ITEM,
        ROW_LIMIT
    } row_kind_t;

    typedef struct packed {
        id_t     granted;
        status_t status;
    } answer_t;

    typedef struct packed {
        row_kind_t kind;
        cmd_t      command;
        id_t       value;
        logic      typed;
        id_t       exp_id;
        status_t   exp_status;
    } stim_row_t;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b1, 11'd1, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b1, 11'd2, ST_DONE},
        '{ROW_ITEM,  CMD_RELEASE, 11'd1,    1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_RELEASE, 11'd1,    1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_RELEASE, 11'd0,    1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_RELEASE, 11'd2047, 1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b1, 11'd3, ST_DONE},
        '{ROW_LIMIT, CMD_ALLOC,   11'd0,    1'b0, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b1, 11'd0, ST_DISABLED},
        '{ROW_ITEM,  CMD_RELEASE, 11'd2,    1'b1, 11'd0, ST_DONE},
        '{ROW_LIMIT, CMD_ALLOC,   11'd2,    1'b0, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b1, 11'd0, ST_FULL},
        '{ROW_ITEM,  CMD_RELEASE, 11'd3,    1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_RELEASE, 11'd2,    1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b0, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b1, 11'd0, ST_FULL},
        '{ROW_LIMIT, CMD_ALLOC,   11'd2047, 1'b0, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_RELEASE, 11'd3,    1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b0, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b0, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_RELEASE, 11'd1024, 1'b1, 11'd0, ST_DONE},
        '{ROW_LIMIT, CMD_ALLOC,   11'd1,    1'b0, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b1, 11'd0, ST_FULL},
        '{ROW_ITEM,  CMD_RELEASE, 11'd1,    1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b1, 11'd0, ST_FULL},
        '{ROW_LIMIT, CMD_ALLOC,   11'd1024, 1'b0, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_RELEASE, 11'd2,    1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_RELEASE, 11'd3,    1'b1, 11'd0, ST_DONE},
        '{ROW_ITEM,  CMD_ALLOC,   11'd0,    1'b0, 11'd0, ST_DONE}
    };

    id_t phase_limit [RANDOM_PHASES] = '{
        11'd5, 11'd1, 11'd33, 11'd0, 11'd2047, 11'd64, 11'd1024, 11'd0
    };
    int phase_items [RANDOM_PHASES] = '{100, 80, 130, 40, 1200, 150, 110, 100};
    int phase_alloc_pct [RANDOM_PHASES] = '{55, 50, 60, 50, 97, 55, 50, 60};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rra_req_if req_ch ();
    rra_rsp_if rsp_ch ();

    round_robin_id_allocator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    bit      id_taken [0:MAX_IDS];
    id_t     search_start;
    id_t     ids_in_use;
    id_t     limit_reg;
    id_t     held_ids [$];
    answer_t expected_answers [$];

    logic    offer_typed;
    answer_t offer_answer;
    bit      no_idling;
    int      hold_asked;
    int      hold_served;
    int      hold_left;
    int      mismatches;
    int      quiet_cycles;

    always #HALF_PERIOD clk = ~clk;

    function automatic void note_failure(string text);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", text);
    endfunction

    function automatic answer_t predict_answer(cmd_t command, id_t rid);
        int      lim;
        int      cand;
        int      here;
        int      tries;
        int      slot;
        bit      found;
        answer_t ans;
        lim = (int'(limit_reg) > MAX_IDS) ? MAX_IDS : int'(limit_reg);
        ans.granted = '0;
        ans.status = ST_DONE;
        found = 1'b0;
        slot = -1;
        if (command == CMD_ALLOC)
        begin
            if (lim == 0)
            begin
                ans.status = ST_DISABLED;
            end
            else if (int'(ids_in_use) >= lim)
            begin
                ans.status = ST_FULL;
            end
            else
            begin
                ans.status = ST_FULL;
                cand = int'(search_start);
                if (cand == 0 || cand > lim)
                    cand = 1;
                for (tries = 0; tries < lim && !found; tries++)
                begin
                    here = cand;
                    cand = (cand >= lim) ? 1 : cand + 1;
                    if (!id_taken[here])
                    begin
                        id_taken[here] = 1'b1;
                        ids_in_use = ids_in_use + 1'b1;
                        search_start = id_t'(cand);
                        ans.granted = id_t'(here);
                        ans.status = ST_DONE;
                        held_ids.push_back(id_t'(here));
                        found = 1'b1;
                    end
                end
            end
        end
        else if (rid != 0 && int'(rid) <= lim && id_taken[rid])
        begin
            id_taken[rid] = 1'b0;
            if (ids_in_use != 0)
                ids_in_use = ids_in_use - 1'b1;
            foreach (held_ids[k])
                if (held_ids[k] == rid)
                    slot = k;
            if (slot >= 0)
                held_ids.delete(slot);
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        answer_t model;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_answers.size() == 0)
            begin
                note_failure($sformatf("result granted_id %0d status %0d with nothing expected",
                                       rsp_ch.granted_id, rsp_ch.status));
            end
            else
            begin
                want = expected_answers.pop_front();
                if (rsp_ch.granted_id !== want.granted)
                    note_failure($sformatf("granted_id expected %0d, got %0d",
                                           want.granted, rsp_ch.granted_id));
                if (rsp_ch.status !== want.status)
                    note_failure($sformatf("status expected %0d, got %0d",
                                           want.status, rsp_ch.status));
            end
        end
        if (req_ch.valid && req_ch.ready)
        begin
            model = predict_answer(cmd_t'(req_ch.command), req_ch.release_id);
            expected_answers.push_back(offer_typed ? offer_answer : model);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("round_robin_id_allocator_core verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The response side holds off for a long stretch when asked, so that the block
    // fills up and stops taking request transactions.
    always @(negedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served <= hold_asked;
            hold_left <= HOLD_OFF_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= no_idling || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic offer_item(cmd_t command, id_t rid, logic typed, answer_t typed_answer);
        while (!no_idling && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.command <= command;
        req_ch.release_id <= rid;
        offer_typed <= typed;
        offer_answer <= typed_answer;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic drain_answers();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(id_t value);
        drain_answers();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MAX_IDS, 2'b00};
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        limit_reg = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_phase(id_t limit_value, int items, int alloc_pct, bit squeeze);
        cmd_t    command;
        id_t     rid;
        answer_t unused;
        int      n;
        unused = '0;
        write_limit(limit_value);
        if (squeeze)
            hold_asked++;
        for (n = 0; n < items; n++)
        begin
            command = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_RELEASE;
            if (held_ids.size() != 0 && $urandom_range(99) < RELEASE_HELD_PCT)
                rid = held_ids[$urandom_range(held_ids.size() - 1)];
            else
                rid = id_t'($urandom_range(2047));
            offer_item(command, rid, 1'b0, unused);
        end
    endtask

    initial
    begin
        int      r;
        int      p;
        answer_t typed_answer;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_ALLOC;
        req_ch.release_id = '0;
        rsp_ch.ready = 1'b0;
        offer_typed = 1'b0;
        offer_answer = '0;
        no_idling = 1'b0;
        hold_asked = 0;
        hold_served = 0;
        hold_left = 0;
        mismatches = 0;
        quiet_cycles = 0;
        limit_reg = id_t'(MAX_IDS);
        search_start = 11'd1;
        ids_in_use = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_LIMIT)
            begin
                write_limit(directed_rows[r].value);
            end
            else
            begin
                typed_answer.granted = directed_rows[r].exp_id;
                typed_answer.status = directed_rows[r].exp_status;
                offer_item(directed_rows[r].command, directed_rows[r].value,
                           directed_rows[r].typed, typed_answer);
            end
        end

        phase_limit[RANDOM_PHASES - 1] = id_t'($urandom_range(2047));
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            no_idling = (p == QUIET_PHASE);
            run_phase(phase_limit[p], phase_items[p], phase_alloc_pct[p], p == SQUEEZE_PHASE);
        end
        no_idling = 1'b0;

        drain_answers();
        if (mismatches == 0)
            $display("round_robin_id_allocator_core verification clean");
        else
            $display("round_robin_id_allocator_core verification failed");
        $finish;
    end

endmodule

[round_robin_id_allocator_core.f]
rtl/core/rra_pkg.sv
rtl/core/rra_if.sv
rtl/core/rra_ram.sv
rtl/core/rra_scan.sv
rtl/core/round_robin_id_allocator_core.sv
bench/round_robin_id_allocator_core_tb.sv
